// File: design/rbst_pkg.sv
// shared types and codes for the ray box slab test
package rbst_pkg;

  typedef logic [1:0] axis_t;

  // axis selector codes carried in tuser
  localparam axis_t AXIS_START = 2'd0;
  localparam axis_t AXIS_LAST  = 2'd2;
  localparam axis_t AXIS_NONE  = 2'd3;

  // result stream carries the hit flag in one byte
  localparam int OUT_DATA_W = 8;

endpackage

// File: design/rbst_div.sv
// iterative signed fixed-point slab distance divider with saturation
module rbst_div
  import rbst_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [COORD_WIDTH-1:0] num,
  input  logic signed [COORD_WIDTH-1:0] sub,
  input  logic signed [COORD_WIDTH-1:0] den,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] result
);

  localparam int W     = COORD_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int N     = W + 1 + F;
  localparam int CMP_W = F + 2 + W;
  localparam int CNT_W = $clog2(W);

  localparam logic [2:0] D_IDLE = 3'd0;
  localparam logic [2:0] D_PREP = 3'd1;
  localparam logic [2:0] D_SAT  = 3'd2;
  localparam logic [2:0] D_RUN  = 3'd3;
  localparam logic [2:0] D_SIGN = 3'd4;

  logic [2:0]          state;
  logic signed [W:0]   diff;
  logic [W-1:0]        den_r;
  logic [N-1:0]        numer;
  logic [W-1:0]        dvmag;
  logic                neg;
  logic                sat;
  logic [W-1:0]        rem;
  logic [W-2:0]        low_bits;
  logic [W-2:0]        quot;
  logic [CNT_W-1:0]    cnt;

  logic [W:0]          mag;
  logic [CMP_W-1:0]    hi_ext;
  logic [CMP_W-1:0]    dv_ext;
  logic [W:0]          trial;
  logic [W:0]          trial_sub;
  logic                trial_ge;
  logic [W-1:0]        q_ext;
  logic [W-1:0]        max_val;
  logic [W-1:0]        min_val;

  always_comb begin
    mag       = diff[W] ? (~diff + 1'b1) : diff;
    hi_ext    = CMP_W'(numer[N-1:W-1]);
    dv_ext    = CMP_W'(dvmag);
    trial     = {rem, low_bits[W-2]};
    trial_ge  = trial >= {1'b0, dvmag};
    trial_sub = trial - {1'b0, dvmag};
    q_ext     = {1'b0, quot};
    max_val   = {1'b0, {(W-1){1'b1}}};
    min_val   = {1'b1, {(W-1){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == D_SIGN);
      unique case (state)
        D_IDLE: begin
          if (start) begin
            diff  <= {num[W-1], num} - {sub[W-1], sub};
            den_r <= den;
            state <= D_PREP;
          end
        end
        D_PREP: begin
          numer <= {mag, {F{1'b0}}};
          dvmag <= den_r[W-1] ? (~den_r + 1'b1) : den_r;
          neg   <= diff[W] ^ den_r[W-1];
          state <= D_SAT;
        end
        D_SAT: begin
          // quotient reaches 2^(W-1) exactly when the high part reaches the divisor
          sat      <= hi_ext >= dv_ext;
          rem      <= hi_ext[W-1:0];
          low_bits <= numer[W-2:0];
          cnt      <= CNT_W'(W - 2);
          state    <= D_RUN;
        end
        D_RUN: begin
          rem      <= trial_ge ? trial_sub[W-1:0] : trial[W-1:0];
          quot     <= {quot[W-3:0], trial_ge};
          low_bits <= low_bits << 1;
          if (cnt == '0) begin
            state <= D_SIGN;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        D_SIGN: begin
          if (sat) begin
            result <= neg ? min_val : max_val;
          end else begin
            result <= neg ? (~q_ext + 1'b1) : q_ext;
          end
          state <= D_IDLE;
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/ray_box_slab_test.sv
// ray against axis-aligned box slab test, one axis per input transfer
// each axis goes through the check, two divisions, order, narrow, test and finish states;
//   the check leads straight to finish when the direction is zero or the test has already missed
// a new axis is taken only in the idle state, so the input stalls while the shared
//   bit-serial divider runs twice per axis
// reset: sync, active high; clears the interval to [0, 0], the miss flag and the result
module ray_box_slab_test
  import rbst_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  localparam int IN_DATA_W  = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // t_low, t_high, slab_low, slab_high, ray_origin, ray_direction, zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // axis
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // hit, zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int W = COORD_WIDTH;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_DIV0   = 3'd2;
  localparam logic [2:0] S_DIV1   = 3'd3;
  localparam logic [2:0] S_ORDER  = 3'd4;
  localparam logic [2:0] S_NARROW = 3'd5;
  localparam logic [2:0] S_TEST   = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0]          state;
  axis_t               axis_r;
  logic signed [W-1:0] slab_lo;
  logic signed [W-1:0] slab_hi;
  logic signed [W-1:0] origin;
  logic signed [W-1:0] dir;
  logic signed [W-1:0] run_low;
  logic signed [W-1:0] run_high;
  logic                missed;
  logic signed [W-1:0] t0;
  logic signed [W-1:0] near_t;
  logic signed [W-1:0] far_t;
  logic                hit;

  logic                in_xfer;
  axis_t               in_axis;
  logic                out_load;
  logic                div_start;
  logic signed [W-1:0] div_num;
  logic                div_done;
  logic signed [W-1:0] div_result;

  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign in_axis       = s_axis_tuser;
  assign m_axis_tdata  = {{(OUT_DATA_W-1){1'b0}}, hit};
  assign out_load      = (state == S_FINISH) && (axis_r == AXIS_LAST) &&
                         (!m_axis_tvalid || m_axis_tready);

  // first distance from the lower bound, second from the upper bound
  assign div_start = ((state == S_CHECK) && !missed && (dir != '0)) ||
                     ((state == S_DIV0) && div_done);
  assign div_num   = (state == S_CHECK) ? slab_lo : slab_hi;

  rbst_div #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .sub    (origin),
    .den    (dir),
    .done   (div_done),
    .result (div_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      run_low       <= '0;
      run_high      <= '0;
      missed        <= 1'b0;
      hit           <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer && (in_axis != AXIS_NONE)) begin
            axis_r  <= in_axis;
            slab_lo <= s_axis_tdata[2*W +: W];
            slab_hi <= s_axis_tdata[3*W +: W];
            origin  <= s_axis_tdata[4*W +: W];
            dir     <= s_axis_tdata[5*W +: W];
            if (in_axis == AXIS_START) begin
              run_low  <= s_axis_tdata[0 +: W];
              run_high <= s_axis_tdata[W +: W];
              missed   <= 1'b0;
            end
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          priority if (missed) begin
            state <= S_FINISH;
          end else if (dir == '0) begin
            // parallel ray: inside the slab or a miss
            missed <= (origin < slab_lo) || (origin > slab_hi);
            state  <= S_FINISH;
          end else begin
            state <= S_DIV0;
          end
        end
        S_DIV0: begin
          if (div_done) begin
            t0    <= div_result;
            state <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            near_t <= (t0 < div_result) ? t0 : div_result;
            far_t  <= (t0 < div_result) ? div_result : t0;
            state  <= S_ORDER;
          end
        end
        S_ORDER: begin
          if (near_t > run_low) begin
            run_low <= near_t;
          end
          state <= S_NARROW;
        end
        S_NARROW: begin
          if (far_t < run_high) begin
            run_high <= far_t;
          end
          state <= S_TEST;
        end
        S_TEST: begin
          missed <= (run_high <= run_low);
          state  <= S_FINISH;
        end
        S_FINISH: begin
          if (axis_r == AXIS_LAST) begin
            if (out_load) begin
              hit   <= !missed;
              state <= S_IDLE;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/rbst_checker.sv
// port-level checks for the ray box slab test, bound to the top level
module rbst_checker
  import rbst_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [1:0]            s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // a held result keeps its flag
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // nothing left on the result side after reset
  assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // a real axis occupies the block for the following cycle
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser != AXIS_NONE) |=> !s_axis_tready)
    else $error("ready stayed high after an axis transfer");

  // an ignored selector does not stall the input
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == AXIS_NONE) |=> s_axis_tready)
    else $error("ignored transfer stalled the input");

endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
